### rtl/core/bsr_pkg.sv
// Bad sector recorder package: default sizes, register indexes and codes.
// Shared by the recorder top level and its divider.
package bsr_pkg;

  localparam int TABLE_ENTRIES_DEF = 126;
  localparam int BLOCK_BITS_DEF    = 24;
  localparam int DIVISOR_BITS      = 16;

  localparam logic [7:0]  SPT_RESET = 8'd32;
  localparam logic [15:0] SPC_RESET = 16'd608;
  localparam logic [6:0]  CLASS_MAX = 7'd127;

  typedef enum logic [1:0] {
    REG_SPT      = 2'd0,
    REG_SPC      = 2'd1,
    REG_SKIP_DEV = 2'd2,
    REG_SEVERE   = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUP       = 2'd1,
    ST_BAD_FULL  = 2'd2,
    ST_SKIP_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    W_NONE   = 2'd0,
    W_BAD    = 2'd1,
    W_SKIP   = 2'd2,
    W_SEVERE = 2'd3
  } where_t;

  typedef enum logic [2:0] {
    K_CLEAR,
    K_SEVERE,
    K_FULL_BAD,
    K_FULL_SKIP,
    K_TABLE
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_CYL,
    S_DIV_TRK,
    S_SCAN,
    S_DONE
  } state_t;

  localparam logic REQ_CLEAR = 1'b1;

endpackage

### rtl/core/bsr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bsr_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = $clog2(D > 1 ? D : 2)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/bsr_div.sv
// Restoring divider, one quotient bit per cycle, for the block split.
// Uses bsr_pkg for the divisor width.
module bsr_div
  import bsr_pkg::*;
#(
  parameter int WN = BLOCK_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [WN-1:0]           dividend,
  input  logic [DIVISOR_BITS-1:0] divisor,
  output logic                    done,
  output logic [WN-1:0]           quot,
  output logic [DIVISOR_BITS-1:0] rem
);

  localparam int CNTW = $clog2(WN + 1);

  logic                    busy;
  logic [CNTW-1:0]         cnt;
  logic [DIVISOR_BITS-1:0] dvs;
  logic [DIVISOR_BITS:0]   trial;
  logic                    fits;

  assign trial = {rem, quot[WN-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(WN);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[WN-2:0], fits};
      rem  <= fits ? DIVISOR_BITS'(trial - {1'b0, dvs}) : trial[DIVISOR_BITS-1:0];
    end
  end

endmodule

### rtl/core/bad_sector_recorder.sv
// Bad sector recorder: table mode runs the bit-serial divider twice for the split
// (cylinder, then track and sector). Severe mode scans its list, one entry read
// per cycle from the list RAM. A clear or a table-mode full refusal goes straight
// to the result state. Synchronous reset clears counts, state and settings;
// table contents are not cleared.
module bad_sector_recorder
  import bsr_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int BLOCK_BITS    = BLOCK_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [BLOCK_BITS-1:0] block_number,
  input  logic [2:0]            error_class,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic [1:0]            stored_in,
  output logic [6:0]            entry_index,
  output logic signed [16:0]    cylinder,
  output logic [15:0]           track_sector,
  output logic [6:0]            bad_total,
  output logic [6:0]            skip_total,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  localparam int CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int SAW = $clog2(TABLE_ENTRIES > 1 ? TABLE_ENTRIES : 2);
  localparam int TAW = $clog2(2 * TABLE_ENTRIES);
  localparam logic [CW-1:0]  N_ENT     = CW'(TABLE_ENTRIES);
  localparam logic [TAW-1:0] SKIP_BASE = TAW'(TABLE_ENTRIES);

  // configuration
  logic [7:0]  spt;
  logic [15:0] spc;
  logic        skip_dev;
  logic        severe;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      spt      <= SPT_RESET;
      spc      <= SPC_RESET;
      skip_dev <= 1'b0;
      severe   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_SPT:      spt      <= cfg_data[7:0];
        REG_SPC:      spc      <= cfg_data;
        REG_SKIP_DEV: skip_dev <= cfg_data[0];
        REG_SEVERE:   severe   <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // control state
  state_t state, state_next;
  kind_t  kind;
  logic [BLOCK_BITS-1:0] bn;
  logic [2:0]            cls;
  logic [CW-1:0] bad_count, skip_count, sev_count;
  logic [CW-1:0] bad_count_next, skip_count_next, sev_count_next;
  logic [6:0]    class_counts [4];
  logic [CW-1:0] sidx;
  logic          cmp_v;
  logic          found;
  logic [15:0]   cyl_sat;

  logic in_acc, load;
  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign load     = (state == S_DONE) && (!out_valid || out_ready);

  // divider
  logic                    div_start, div_done;
  logic [BLOCK_BITS-1:0]   div_dividend, div_quot;
  logic [DIVISOR_BITS-1:0] div_divisor, div_rem;

  bsr_div #(.WN(BLOCK_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // memories: bad entries in the low half of the table RAM, skip entries above
  logic            tbl_we;
  logic [TAW-1:0]  tbl_waddr, tbl_raddr;
  logic [32:0]     tbl_wdata, tbl_rdata;
  logic            sev_we;
  logic [SAW-1:0]  sev_raddr;
  logic [BLOCK_BITS-1:0] sev_rdata;

  assign tbl_raddr = SKIP_BASE + TAW'(skip_count) - 1'b1;
  assign sev_raddr = sidx[SAW-1:0];

  bsr_ram #(.W(33), .D(2 * TABLE_ENTRIES)) u_tables (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  bsr_ram #(.W(BLOCK_BITS), .D(TABLE_ENTRIES)) u_severe (
    .clk   (clk),
    .we    (sev_we),
    .waddr (sev_count[SAW-1:0]),
    .wdata (bn),
    .raddr (sev_raddr),
    .rdata (sev_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (req_type == REQ_CLEAR) begin
            state_next = S_DONE;
          end else if (severe) begin
            state_next = S_SCAN;
          end else if (bad_count == N_ENT || skip_count == N_ENT) begin
            state_next = S_DONE;
          end else begin
            state_next = S_DIV_CYL;
          end
        end
      end
      S_DIV_CYL: if (div_done) state_next = S_DIV_TRK;
      S_DIV_TRK: if (div_done) state_next = S_DONE;
      S_SCAN:    if (sidx == sev_count && !cmp_v) state_next = S_DONE;
      S_DONE:    if (load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // datapath control and result
  logic [15:0]  spc_eff;
  logic [7:0]   spt_eff;
  logic         to_skip;
  logic [16:0]  cyl_val;
  logic [15:0]  ts_val;
  status_t      res_status;
  where_t       res_where;
  logic [CW-1:0] res_idx;
  logic         count_cls;
  logic         clear_cls;

  assign spc_eff = (spc == '0) ? 16'd1 : spc;
  assign spt_eff = (spt == '0) ? 8'd1 : spt;
  assign ts_val  = {div_quot[7:0], div_rem[7:0]};

  always_comb begin
    div_start    = 1'b0;
    div_dividend = bn;
    div_divisor  = spc_eff;
    if (state == S_IDLE && state_next == S_DIV_CYL) begin
      div_start    = 1'b1;
      div_dividend = block_number;
    end else if (state == S_DIV_CYL && div_done) begin
      div_start    = 1'b1;
      div_dividend = BLOCK_BITS'(div_rem);
      div_divisor  = {8'd0, spt_eff};
    end
  end

  always_comb begin
    bad_count_next  = bad_count;
    skip_count_next = skip_count;
    sev_count_next  = sev_count;
    res_status      = ST_OK;
    res_where       = W_NONE;
    res_idx         = '0;
    cyl_val         = '0;
    tbl_we          = 1'b0;
    tbl_waddr       = TAW'(bad_count);
    sev_we          = 1'b0;
    count_cls       = 1'b0;
    clear_cls       = 1'b0;
    to_skip         = 1'b0;
    if (load) begin
      unique case (kind)
        K_CLEAR: begin
          bad_count_next  = '0;
          skip_count_next = '0;
          sev_count_next  = '0;
          clear_cls       = 1'b1;
        end
        K_SEVERE: begin
          priority if (found) begin
            res_status = ST_DUP;
          end else if (sev_count == N_ENT) begin
            res_status = ST_BAD_FULL;
          end else begin
            res_idx        = sev_count;
            res_where      = W_SEVERE;
            sev_we         = 1'b1;
            sev_count_next = sev_count + 1'b1;
            count_cls      = 1'b1;
          end
        end
        K_FULL_BAD:  res_status = ST_BAD_FULL;
        K_FULL_SKIP: res_status = ST_SKIP_FULL;
        K_TABLE: begin
          count_cls = 1'b1;
          cyl_val   = {1'b0, cyl_sat};
          if (skip_dev) begin
            to_skip = (skip_count == '0) || (tbl_rdata[15:8] != ts_val[15:8]);
            if (!to_skip) cyl_val = 17'd0 - {1'b0, cyl_sat};
          end
          tbl_we = 1'b1;
          if (to_skip) begin
            res_idx         = skip_count;
            res_where       = W_SKIP;
            tbl_waddr       = SKIP_BASE + TAW'(skip_count);
            skip_count_next = skip_count + 1'b1;
          end else begin
            res_idx        = bad_count;
            res_where      = W_BAD;
            bad_count_next = bad_count + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign tbl_wdata = {cyl_val, ts_val};

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bad_count  <= '0;
      skip_count <= '0;
      sev_count  <= '0;
      out_valid  <= 1'b0;
      cmp_v      <= 1'b0;
      for (int i = 0; i < 4; i++) class_counts[i] <= '0;
    end else begin
      state      <= state_next;
      bad_count  <= bad_count_next;
      skip_count <= skip_count_next;
      sev_count  <= sev_count_next;
      if (clear_cls) begin
        for (int i = 0; i < 4; i++) class_counts[i] <= '0;
      end else if (count_cls && !cls[2] && class_counts[cls[1:0]] != CLASS_MAX) begin
        class_counts[cls[1:0]] <= class_counts[cls[1:0]] + 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      cmp_v <= (state == S_SCAN) && (sidx != sev_count);
    end
  end

  logic [CW+6:0] idx_ext, bad_ext, skip_ext;
  assign idx_ext  = (CW + 7)'(res_idx);
  assign bad_ext  = (CW + 7)'(bad_count_next);
  assign skip_ext = (CW + 7)'(skip_count_next);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      bn   <= block_number;
      cls  <= error_class;
      sidx <= '0;
      found <= 1'b0;
      priority if (req_type == REQ_CLEAR) kind <= K_CLEAR;
      else if (severe)                    kind <= K_SEVERE;
      else if (bad_count == N_ENT)        kind <= K_FULL_BAD;
      else if (skip_count == N_ENT)       kind <= K_FULL_SKIP;
      else                                kind <= K_TABLE;
    end else if (state == S_SCAN) begin
      if (sidx != sev_count) sidx <= sidx + 1'b1;
      if (cmp_v && sev_rdata == bn) found <= 1'b1;
    end
    if (state == S_DIV_CYL && div_done) begin
      cyl_sat <= (div_quot > BLOCK_BITS'(16'hffff)) ? 16'hffff : div_quot[15:0];
    end
    if (load) begin
      status       <= res_status;
      stored_in    <= res_where;
      entry_index  <= idx_ext[6:0];
      cylinder     <= cyl_val;
      track_sector <= (kind == K_TABLE) ? ts_val : 16'd0;
      bad_total    <= bad_ext[6:0];
      skip_total   <= skip_ext[6:0];
    end
  end

`ifndef SYNTHESIS
  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    bad_count <= N_ENT && skip_count <= N_ENT && sev_count <= N_ENT)
    else $error("table count beyond capacity");

  a_one_store: assert property (@(posedge clk) disable iff (rst)
    !(tbl_we && sev_we))
    else $error("two stores for one transaction");

  a_skip_step: assert property (@(posedge clk) disable iff (rst)
    (tbl_we && tbl_waddr >= SKIP_BASE) |=> skip_count == $past(skip_count) + 1'b1)
    else $error("skip store without count step");

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result loaded outside final state");
`endif

endmodule

### test/tb_top.sv
// Self-checking testbench for bad_sector_recorder: directed table, then random traffic.
// Predicts every result transaction in-house and compares all its fields.
// Depends on bsr_pkg and the recorder RTL.
`timescale 1ns / 1ps
module tb_top
  import bsr_pkg::*;
();

  localparam int ENTRIES = 126;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         stored_in;
    logic [6:0]         entry_index;
    logic signed [16:0] cylinder;
    logic [15:0]        track_sector;
    logic [6:0]         bad_total;
    logic [6:0]         skip_total;
  } outcome_t;

  typedef struct {
    logic        req;
    logic [23:0] blk;
    logic [2:0]  cls;
    logic        known;
    outcome_t    res;
  } row_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, req_type = 0;
  logic [23:0] block_number = 0;
  logic [2:0] error_class = 0;
  logic out_valid, out_ready = 0;
  logic [1:0] status, stored_in;
  logic [6:0] entry_index, bad_total, skip_total;
  logic signed [16:0] cylinder;
  logic [15:0] track_sector;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  bad_sector_recorder u_top (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // predictor state
  logic [7:0]  spt;
  logic [15:0] spc;
  logic        skip_dev, severe;
  logic [15:0] skip_ts [ENTRIES];
  logic [23:0] severe_blk [ENTRIES];
  int bad_cnt, skip_cnt, sev_cnt;
  int class_cnt [4];

  outcome_t expected_q [$];
  int mismatches = 0, results_seen = 0, items_sent = 0, timeouts = 0;
  int send_idle = 0, recv_stall = 0, hold_cycles = 0;
  longint cycles = 0;

  function automatic outcome_t predict_record(logic req, logic [23:0] blk, logic [2:0] cls);
    outcome_t r;
    logic found;
    logic [31:0] dspc, dspt, cn, rem, tn, sn;
    logic to_skip;
    r = '0;
    if (req == REQ_CLEAR) begin
      bad_cnt = 0; skip_cnt = 0; sev_cnt = 0;
      for (int k = 0; k < 4; k++) class_cnt[k] = 0;
    end else if (severe) begin
      found = 0;
      for (int k = 0; k < sev_cnt; k++) if (severe_blk[k] == blk) found = 1;
      if (found) r.status = ST_DUP;
      else if (sev_cnt >= ENTRIES) r.status = ST_BAD_FULL;
      else begin
        r.entry_index = 7'(sev_cnt);
        severe_blk[sev_cnt] = blk;
        sev_cnt++;
        r.stored_in = W_SEVERE;
        if (cls < 4 && class_cnt[cls] < CLASS_MAX) class_cnt[cls]++;
      end
    end else if (bad_cnt >= ENTRIES) r.status = ST_BAD_FULL;
    else if (skip_cnt >= ENTRIES) r.status = ST_SKIP_FULL;
    else begin
      dspc = (spc == 0) ? 1 : spc;
      dspt = (spt == 0) ? 1 : spt;
      cn = blk / dspc; rem = blk % dspc;
      tn = rem / dspt; sn = rem % dspt;
      if (cls < 4 && class_cnt[cls] < CLASS_MAX) class_cnt[cls]++;
      if (cn > 65535) cn = 65535;
      r.track_sector = 16'((tn << 8) + sn);
      r.cylinder = 17'(cn);
      to_skip = 0;
      if (skip_dev) begin
        to_skip = (skip_cnt == 0) || (skip_ts[skip_cnt-1][15:8] != r.track_sector[15:8]);
        if (!to_skip) r.cylinder = 17'(-cn);
      end
      if (to_skip) begin
        r.entry_index = 7'(skip_cnt);
        skip_ts[skip_cnt] = r.track_sector;
        skip_cnt++;
        r.stored_in = W_SKIP;
      end else begin
        r.entry_index = 7'(bad_cnt);
        bad_cnt++;
        r.stored_in = W_BAD;
      end
    end
    r.bad_total = 7'(bad_cnt);
    r.skip_total = 7'(skip_cnt);
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      outcome_t got, want;
      got = '{status, stored_in, entry_index, cylinder, track_sector, bad_total, skip_total};
      results_seen <= results_seen + 1;
      if (expected_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result transaction %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // receiver: random stall, long hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 0;
    end else
      out_ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send_item(logic req, logic [23:0] blk, logic [2:0] cls);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; req_type <= req; block_number <= blk; error_class <= cls;
    expected_q.push_back(predict_record(req, blk, cls));
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SPT:      spt = val[7:0];
      REG_SPC:      spc = val;
      REG_SKIP_DEV: skip_dev = val[0];
      REG_SEVERE:   severe = val[0];
    endcase
  endtask

  task automatic configure(logic [7:0] t, logic [15:0] c, logic sd, logic sv);
    drain();
    write_reg(REG_SPT, {8'd0, t});
    write_reg(REG_SPC, c);
    write_reg(REG_SKIP_DEV, {15'd0, sd});
    write_reg(REG_SEVERE, {15'd0, sv});
    cfg_valid <= 0;
  endtask

  function automatic logic [23:0] rand_block(int mode);
    case (mode)
      0: return 24'($urandom_range(24'hffffff));
      1: return 24'($urandom_range(4095));
      default: return {$urandom_range(1) ? 24'hffffff : 24'h0} ^ (24'd1 << $urandom_range(23));
    endcase
  endfunction

  task automatic random_phase(int n, int sidle, int rstall);
    logic [23:0] recent [$];
    logic [23:0] b;
    send_idle = sidle; recv_stall = rstall;
    for (int k = 0; k < n; k++) begin
      if (recent.size() > 0 && $urandom_range(3) == 0)
        b = recent[$urandom_range(recent.size()-1)];
      else b = rand_block($urandom_range(2));
      recent.push_back(b);
      if (recent.size() > 8) void'(recent.pop_front());
      send_item($urandom_range(59) == 0, b, 3'($urandom_range(7)));
    end
  endtask

  row_t plan [$];

  initial begin
    spt = SPT_RESET; spc = SPC_RESET; skip_dev = 0; severe = 0;
    bad_cnt = 0; skip_cnt = 0; sev_cnt = 0;
    for (int k = 0; k < 4; k++) class_cnt[k] = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    plan.push_back('{0, 24'd0, 3'd0, 1, '{ST_OK, W_BAD, 7'd0, 17'sd0, 16'd0, 7'd1, 7'd0}});
    plan.push_back('{0, 24'd609, 3'd1, 1, '{ST_OK, W_BAD, 7'd1, 17'sd1, 16'd1, 7'd2, 7'd0}});
    plan.push_back('{0, 24'hffffff, 3'd4, 0, '0});
    plan.push_back('{0, 24'd640, 3'd7, 0, '0});
    plan.push_back('{1, 24'd5, 3'd2, 1, '0});
    plan.push_back('{0, 24'd12345, 3'd3, 0, '0});
    foreach (plan[k]) begin
      outcome_t p;
      p = predict_record(plan[k].req, plan[k].blk, plan[k].cls);
      if (plan[k].known && p !== plan[k].res) begin
        mismatches++;
        $display("directed row %0d disagrees with predictor", k);
      end
    end
    // rewind predictor and replay through the DUT
    bad_cnt = 0; skip_cnt = 0; sev_cnt = 0;
    for (int k = 0; k < 4; k++) class_cnt[k] = 0;
    foreach (plan[k]) send_item(plan[k].req, plan[k].blk, plan[k].cls);

    configure(8'd1, 16'd1, 1, 0);
    send_item(0, 24'hffffff, 3'd0);
    send_item(0, 24'd70000, 3'd2);
    send_item(0, 24'd3, 3'd1);
    send_item(0, 24'd3, 3'd1);
    configure(8'd0, 16'd0, 1, 0);
    send_item(0, 24'd300, 3'd0);
    send_item(0, 24'd301, 3'd0);
    configure(8'd255, 16'd65535, 0, 1);
    send_item(0, 24'd77, 3'd0);
    send_item(0, 24'd77, 3'd3);
    send_item(0, 24'hffffff, 3'd5);
    send_item(1, 24'd0, 3'd0);

    configure(8'd17, 16'd255, 1, 0);
    random_phase(180, 0, 0);
    // fill tables to the brim, then check refusals
    random_phase(100, 79, 0);
    configure(8'd32, 16'd608, 0, 1);
    send_item(1, 24'd0, 3'd0);
    random_phase(150, 0, 79);
    configure(8'd255, 16'd65535, 0, 0);
    random_phase(150, 8, 8);
    configure(8'd7, 16'd49, 1, 0);
    send_idle = 0; recv_stall = 0;
    hold_cycles = 400;
    for (int k = 0; k < 20; k++) send_item(0, rand_block(1), 3'($urandom_range(7)));
    random_phase(150, 8, 8);

    drain();
    $display("%0d items sent, %0d results checked, %0d mismatches", items_sent,
             results_seen, mismatches);
    $display("covered table and severe modes, skip drives, full tables and clears");
    if (mismatches == 0 && results_seen == items_sent) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
